// File: sv/running_median_tracker_macros.svh
// ----------------------------------------------------------------------------
// running median tracker assertion macros
// concurrent assertion shorthands on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEDIAN_TRACKER_MACROS_SVH
`define RUNNING_MEDIAN_TRACKER_MACROS_SVH

// same-cycle implication
`define RMT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rmt_pkg.sv
// ----------------------------------------------------------------------------
// rmt_pkg
// shared widths and cell operation codes of the running median tracker
// ----------------------------------------------------------------------------
package rmt_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned MedianW = 33;
  localparam int unsigned CountW  = 9;

  // operation that every cell of a chain carries out
  typedef enum logic [1:0] {
    CellHold   = 2'd0,
    CellInsert = 2'd1,
    CellPush   = 2'd2,
    CellPop    = 2'd3
  } cell_op_e;

endpackage

// File: sv/rmt_if.sv
// ----------------------------------------------------------------------------
// rmt_in_if / rmt_out_if
// valid/ready channels carrying input and result words
// ----------------------------------------------------------------------------
interface rmt_in_if import rmt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample;
  logic                      start_req;

  modport source (output valid, output sample, output start_req, input ready);
  modport sink   (input valid, input sample, input start_req, output ready);
endinterface

interface rmt_out_if import rmt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [MedianW-1:0] median_doubled;
  logic        [CountW-1:0]  held_count;
  logic                      full_res;

  modport source (output valid, output median_doubled, output held_count,
                  output full_res, input ready);
  modport sink   (input valid, input median_doubled, input held_count,
                  input full_res, output ready);
endinterface

// File: sv/running_median_tracker.sv
// ----------------------------------------------------------------------------
// running_median_tracker
// running median of a signed stream held in two sorted cell chains
// ----------------------------------------------------------------------------
// Each input word carries one signed sample; the block inserts it into a
// store of up to CAPACITY values and returns one result word: twice the
// median of every value held (odd count: twice the middle value, even count:
// the full-width sum of the two middle values), the count held and a full
// flag. start_req empties the store before the sample goes in. A sample that
// arrives while the store is full and start_req is low is dropped, full_res
// is raised and the median is reported unchanged. The store is split into a
// lower half kept in descending order and an upper half kept in ascending
// order, each a row of cells that shift into their neighbors, so the two
// middle values always sit in the head cells. An item goes through the
// accept, one insert step through a chain, one rebalance step that
// moves a head value across to the other chain, and the load of the output
// register; a result still waiting in the output register holds the last
// step until it is taken. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "running_median_tracker_macros.svh"

module running_median_tracker import rmt_pkg::*; #(
  parameter int unsigned CAPACITY    = 256,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rmt_in_if.sink    in_i,
  rmt_out_if.source out_o
);

  localparam int unsigned VW    = VALUE_WIDTH;
  localparam int unsigned DEPTH = CAPACITY / 2 + 1;        // cells per half
  localparam int unsigned HW    = $clog2(DEPTH + 1);
  localparam int unsigned NW    = $clog2(CAPACITY + 1);

  // sequencer codes
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StIns  = 2'd1;
  localparam logic [1:0] StBal  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [HW-1:0]        nl_q, nl_d;       // lower half fill
  logic [HW-1:0]        nu_q, nu_d;       // upper half fill
  logic signed [VW-1:0] v_q;              // sample being inserted
  logic                 refused_q;

  logic signed [VW-1:0] low_head, up_head;
  cell_op_e             low_op, up_op;

  logic [NW-1:0]        n_now;
  logic [HW:0]          nl_x, nu_x;
  logic                 accept, out_free;

  // result register
  logic                      out_valid_q;
  logic signed [MedianW-1:0] out_med_q;
  logic [CountW-1:0]         out_held_q;
  logic                      out_full_q;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == StIdle);

  assign n_now = NW'(nl_q) + NW'(nu_q);
  assign nl_x  = {1'b0, nl_q};
  assign nu_x  = {1'b0, nu_q};

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    nl_d    = nl_q;
    nu_d    = nu_q;
    low_op  = CellHold;
    up_op   = CellHold;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StIns;
          if (in_i.start_req) begin
            nl_d = '0;
            nu_d = '0;
          end
        end
      end
      StIns: begin
        state_d = StBal;
        if (!refused_q) begin
          // ties go low; order among equal values leaves the median alone
          if (nl_q == '0 || !(v_q > low_head)) begin
            low_op = CellInsert;
            nl_d   = nl_q + 1'b1;
          end else begin
            up_op = CellInsert;
            nu_d  = nu_q + 1'b1;
          end
        end
      end
      StBal: begin
        state_d = StOut;
        if (nl_x > nu_x + 1'b1) begin
          // lower max moves to upper head
          low_op = CellPop;
          up_op  = CellPush;
          nl_d   = nl_q - 1'b1;
          nu_d   = nu_q + 1'b1;
        end else if (nu_x > nl_x) begin
          // upper min moves to lower head
          low_op = CellPush;
          up_op  = CellPop;
          nl_d   = nl_q + 1'b1;
          nu_d   = nu_q - 1'b1;
        end
      end
      StOut: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      nl_q    <= '0;
      nu_q    <= '0;
    end else begin
      state_q <= state_d;
      nl_q    <= nl_d;
      nu_q    <= nu_d;
    end
  end

  // latch the sample; refusal is decided on the count after a start clear
  always_ff @(posedge clk_i) begin
    if (accept) begin
      v_q       <= VW'($signed(in_i.sample));
      refused_q <= !in_i.start_req && (n_now == NW'(CAPACITY));
    end
  end

  // ---------------------------------------------------------------- chains
  rmt_chain #(
    .VW    (VW),
    .DEPTH (DEPTH),
    .DESC  (1'b1)
  ) u_low (
    .clk_i     (clk_i),
    .op_i      (low_op),
    .count_i   (nl_q),
    .sample_i  (v_q),
    .head_in_i (up_head),
    .head_o    (low_head)
  );

  rmt_chain #(
    .VW    (VW),
    .DEPTH (DEPTH),
    .DESC  (1'b0)
  ) u_up (
    .clk_i     (clk_i),
    .op_i      (up_op),
    .count_i   (nu_q),
    .sample_i  (v_q),
    .head_in_i (low_head),
    .head_o    (up_head)
  );

  // ---------------------------------------------------------------- result
  logic [VW:0] med_sum;
  logic [VW:0] low_ext, up_ext;

  assign low_ext = {low_head[VW-1], low_head};
  assign up_ext  = {up_head[VW-1], up_head};
  // odd count when the halves differ: middle value sits in the lower head
  assign med_sum = (nl_q != nu_q) ? (low_ext + low_ext) : (low_ext + up_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == StOut && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StOut && out_free) begin
      out_med_q  <= MedianW'(med_sum);
      out_held_q <= CountW'(n_now);
      out_full_q <= refused_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.median_doubled = out_med_q;
  assign out_o.held_count     = out_held_q;
  assign out_o.full_res       = out_full_q;

  // ---------------------------------------------------------------- checks
  `RMT_ASSERT_IMPL(a_halves_balanced, state_q == StIdle, (nl_q == nu_q) || (nl_x == nu_x + 1'b1), "halves out of balance")
  `RMT_ASSERT_NEXT(a_accept_starts_insert, accept, state_q == StIns, "accepted word did not start insert")
  `RMT_ASSERT_IMPL(a_refused_only_full, out_valid_q && out_full_q, out_held_q == CountW'(CAPACITY), "refusal below capacity")

endmodule

// File: sv/rmt_cell.sv
// ----------------------------------------------------------------------------
// rmt_cell
// one slot of a sorted chain: hold, insert, shift toward tail, shift toward head
// ----------------------------------------------------------------------------
module rmt_cell import rmt_pkg::*; #(
  parameter int unsigned VW   = 32,
  parameter bit          DESC = 1'b0
) (
  input  logic                 clk_i,
  input  cell_op_e             op_i,
  input  logic                 occ_i,
  input  logic signed [VW-1:0] sample_i,
  input  logic signed [VW-1:0] prev_val_i,
  input  logic                 prev_gt_i,
  input  logic signed [VW-1:0] next_val_i,
  output logic signed [VW-1:0] val_o,
  output logic                 gt_o
);

  logic signed [VW-1:0] val_q, val_d;
  logic                 gt;

  // set when the new value goes at or before this slot
  assign gt = !occ_i || (DESC ? (val_q < sample_i) : (val_q > sample_i));

  always_comb begin
    case (op_i)
      CellHold:   val_d = val_q;
      CellInsert: val_d = prev_gt_i ? prev_val_i : (gt ? sample_i : val_q);
      CellPush:   val_d = prev_val_i;
      CellPop:    val_d = next_val_i;
      default:    val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign gt_o  = gt;

endmodule

// File: sv/rmt_chain.sv
// ----------------------------------------------------------------------------
// rmt_chain
// row of cells holding one sorted half, head at cell zero
// ----------------------------------------------------------------------------
module rmt_chain import rmt_pkg::*; #(
  parameter int unsigned VW    = 32,
  parameter int unsigned DEPTH = 129,
  parameter bit          DESC  = 1'b0,
  localparam int unsigned HW   = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  cell_op_e             op_i,
  input  logic [HW-1:0]        count_i,
  input  logic signed [VW-1:0] sample_i,
  input  logic signed [VW-1:0] head_in_i,
  output logic signed [VW-1:0] head_o
);

  logic signed [VW-1:0] val [DEPTH];
  logic                 gt  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VW-1:0] prev_val, next_val;
    logic                 prev_gt;

    if (i == 0) begin : g_head
      assign prev_val = head_in_i;
      assign prev_gt  = 1'b0;
    end else begin : g_body
      assign prev_val = val[i-1];
      assign prev_gt  = gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_val = val[i];
    end else begin : g_mid
      assign next_val = val[i+1];
    end

    rmt_cell #(
      .VW   (VW),
      .DESC (DESC)
    ) u_cell (
      .clk_i      (clk_i),
      .op_i       (op_i),
      .occ_i      (HW'(i) < count_i),
      .sample_i   (sample_i),
      .prev_val_i (prev_val),
      .prev_gt_i  (prev_gt),
      .next_val_i (next_val),
      .val_o      (val[i]),
      .gt_o       (gt[i])
    );
  end

  assign head_o = val[0];

endmodule
